>>> sv/csld_pkg.sv
// Package for the complement-synchronized length deframer.
// Holds the phase codes, result and push types and the queue sizing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csld_pkg;

  // Deframer phases
  localparam logic [1:0] PH_IDLE   = 2'd0;  // no candidate header
  localparam logic [1:0] PH_CAND   = 2'd1;  // candidate header held
  localparam logic [1:0] PH_LENGTH = 2'd2;  // expecting length byte
  localparam logic [1:0] PH_STREAM = 2'd3;  // payload and trailing byte

  // Output queue sizing
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // One result item
  typedef struct packed {
    logic [7:0] packet_byte;
    logic       first_of_packet;
    logic       last_of_packet;
  } result_t;

  // Results written into the queue in one cycle (zero, one or two)
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

>>> sv/csld_if.sv
// Valid/ready channel interfaces for the deframer.
// Input carries received bytes, output carries packet bytes with marks.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface csld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface csld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       first_of_packet;
  logic       last_of_packet;

  modport source (output valid, output packet_byte, output first_of_packet,
                  output last_of_packet, input ready);
  modport sink (input valid, input packet_byte, input first_of_packet,
                input last_of_packet, output ready);
endinterface

`default_nettype wire

>>> sv/csld_core.sv
// Deframer core: input register and per-byte phase update.
// Produces zero, one or two results per item. Depends on csld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csld_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     in_byte_i,
  input  wire logic           room_i,
  output csld_pkg::push_t     push_o
);
  import csld_pkg::*;

  logic       stage_valid_q, stage_valid_d;
  logic [7:0] stage_byte_q;
  logic       fire;

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [8:0] left_q, left_d;
  push_t      push;

  // Staged item is processed once the queue has room for two results
  assign fire          = stage_valid_q & room_i;
  assign in_ready_o    = ~stage_valid_q | fire;
  assign stage_valid_d = in_valid_i | (stage_valid_q & ~fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_byte_q <= in_byte_i;
    end
  end

  // Phase update and result generation
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    left_d  = left_q;
    push    = '0;
    case (phase_q)
      PH_IDLE: begin
        held_d  = stage_byte_q;
        phase_d = PH_CAND;
      end
      PH_CAND: begin
        if (stage_byte_q == ~held_q) begin
          push.num = 2'd2;
          push.r0  = '{packet_byte: held_q, first_of_packet: 1'b1, last_of_packet: 1'b0};
          push.r1  = '{packet_byte: stage_byte_q, first_of_packet: 1'b0,
                       last_of_packet: 1'b0};
          phase_d  = PH_LENGTH;
        end else begin
          held_d = stage_byte_q;
        end
      end
      PH_LENGTH: begin
        push.num = 2'd1;
        push.r0  = '{packet_byte: stage_byte_q, first_of_packet: 1'b0,
                     last_of_packet: 1'b0};
        left_d   = {1'b0, stage_byte_q} + 9'd1;
        phase_d  = PH_STREAM;
      end
      default: begin
        push.num = 2'd1;
        if (left_q <= 9'd1) begin
          // trailing byte ends the packet
          push.r0 = '{packet_byte: stage_byte_q, first_of_packet: 1'b0,
                      last_of_packet: 1'b1};
          left_d  = '0;
          phase_d = PH_IDLE;
        end else begin
          push.r0 = '{packet_byte: stage_byte_q, first_of_packet: 1'b0,
                      last_of_packet: 1'b0};
          left_d  = left_q - 9'd1;
        end
      end
    endcase
    if (!fire) begin
      push.num = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
      left_q  <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/csld_queue.sv
// Small result queue: up to two writes and one read per cycle.
// Registered output side of the deframer. Depends on csld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csld_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  csld_pkg::push_t      push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output csld_pkg::result_t    out_data_o
);
  import csld_pkg::*;

  result_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o & out_ready_i;
  // room for a full pair of results
  assign room_o      = (cnt_q <= QCntW'(QDepth - 2));

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q + QPtrW'(push_i.num);
    rd_d  = rd_q + QPtrW'(pop);
    cnt_d = cnt_q + QCntW'(push_i.num) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + QPtrW'(1)] <= push_i.r1;
    end
  end

endmodule

`default_nettype wire

>>> sv/complement_sync_length_deframer.sv
// Top level of the complement-synchronized length deframer.
// Depends on csld_pkg, csld_if, csld_core and csld_queue.
//
// Takes one received byte per cycle while the queue has room and hunts for a
// header byte followed by its bitwise complement; the pair, the length byte N,
// N payload bytes and one trailing byte are then passed on in order, header
// marked first and trailing byte marked last. Bytes outside a packet are
// dropped. Each byte passes through the input register and then a four-entry
// result queue. One byte is accepted per cycle while the queue holds at most
// two results; the header pair writes two results in one cycle, which the
// queue absorbs.
`timescale 1ns / 1ps
`default_nettype none

module complement_sync_length_deframer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  csld_in_if.sink    rx_i,
  csld_out_if.source pkt_o
);
  import csld_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  // Phase tracking and result generation
  csld_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .in_byte_i  (rx_i.rx_byte),
    .room_i     (room),
    .push_o     (push)
  );

  // Result queue toward the output channel
  csld_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (pkt_o.valid),
    .out_ready_i (pkt_o.ready),
    .out_data_o  (head)
  );

  assign pkt_o.packet_byte     = head.packet_byte;
  assign pkt_o.first_of_packet = head.first_of_packet;
  assign pkt_o.last_of_packet  = head.last_of_packet;

endmodule

`default_nettype wire
